[rtl/mrts_pkg.sv]
// mrts_pkg: shared types and constants for the rate table selector
// no dependencies; imported by mrts_ctrl, mrts_datapath and the top level
`timescale 1ns / 1ps

package mrts_pkg;

    localparam int RATIO_WIDTH_DEF = 20;
    localparam int RATE_WIDTH_DEF  = 16;

    localparam int CODE_W     = 8;
    localparam int WEIGHT_W   = 7;
    localparam int ROLL_W     = 7;
    localparam int STATUS_W   = 2;
    localparam int MODE_W     = 2;
    localparam int TP_SCALE_W = 17;

    localparam logic [WEIGHT_W-1:0]   WEIGHT_RESET   = 7'd75;
    localparam logic [WEIGHT_W-1:0]   PERCENT        = 7'd100;
    localparam logic [ROLL_W-1:0]     SAMPLE_PERCENT = 7'd10;
    localparam logic [TP_SCALE_W-1:0] TP_SCALE       = 17'd100000;

    // quotient bits produced per cycle by the divide-by-hundred unit
    localparam int DIV_BITS = 8;

    typedef enum logic [MODE_W-1:0] {
        MODE_ENTRY   = 2'd0,
        MODE_REQUEST = 2'd1,
        MODE_EMPTY   = 2'd2,
        MODE_UNUSED  = 2'd3
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_CHAIN     = 2'd0,
        STATUS_REDRAW    = 2'd1,
        STATUS_COMMITTED = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MIX1,
        ST_DIV1,
        ST_MIX2,
        ST_DIV2,
        ST_TP,
        ST_UPDATE,
        ST_REQ_MUL,
        ST_REQ_OUT,
        ST_EMPTY
    } state_t;

    typedef struct packed {
        logic load_in;
        logic mix_load;
        logic mix_second;
        logic div_step;
        logic tp_load;
        logic entry_update;
        logic req_mul;
        logic req_out;
        logic empty_apply;
    } ctrl_cmd_t;

    typedef struct packed {
        logic last_entry;
        logic out_free;
    } ctrl_status_t;

endpackage

[rtl/mrts_ctrl.sv]
// mrts_ctrl: sequencing state machine for entries, requests and table resets
// depends on mrts_pkg; drives mrts_datapath through ctrl_cmd_t
`timescale 1ns / 1ps

module mrts_ctrl
    import mrts_pkg::*;
#(
    parameter int RATIO_WIDTH = RATIO_WIDTH_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [MODE_W-1:0]   mode,
    input  ctrl_status_t        status_in,
    output ctrl_cmd_t           cmd
);

    localparam int MIX_W      = RATIO_WIDTH + WEIGHT_W;
    localparam int DIV_CYCLES = (MIX_W + DIV_BITS - 1) / DIV_BITS;
    localparam int CNT_W      = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               cnt_last;

    assign cnt_last = (cnt_reg == CNT_W'(DIV_CYCLES - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
                if (in_valid)
                begin
                    unique case (mode_t'(mode))
                        MODE_ENTRY:   state_next = ST_MIX1;
                        MODE_REQUEST: state_next = ST_REQ_MUL;
                        MODE_EMPTY:   state_next = ST_EMPTY;
                        default:      state_next = ST_IDLE;
                    endcase
                end
            end
            ST_MIX1:
            begin
                cmd.mix_load = 1'b1;
                cnt_next     = '0;
                state_next   = ST_DIV1;
            end
            ST_DIV1:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_last)
                    state_next = ST_MIX2;
            end
            ST_MIX2:
            begin
                cmd.mix_load   = 1'b1;
                cmd.mix_second = 1'b1;
                cnt_next       = '0;
                state_next     = ST_DIV2;
            end
            ST_DIV2:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_last)
                    state_next = ST_TP;
            end
            ST_TP:
            begin
                cmd.tp_load = 1'b1;
                state_next  = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (!status_in.last_entry || status_in.out_free)
                begin
                    cmd.entry_update = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            ST_REQ_MUL:
            begin
                cmd.req_mul = 1'b1;
                state_next  = ST_REQ_OUT;
            end
            ST_REQ_OUT:
            begin
                if (status_in.out_free)
                begin
                    cmd.req_out = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_EMPTY:
            begin
                if (status_in.out_free)
                begin
                    cmd.empty_apply = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/mrts_datapath.sv]
// mrts_datapath: smoothing, divide-by-hundred unit, running selection and output register
// depends on mrts_pkg; sequenced by mrts_ctrl
`timescale 1ns / 1ps

module mrts_datapath
    import mrts_pkg::*;
#(
    parameter int RATIO_WIDTH = RATIO_WIDTH_DEF,
    parameter int RATE_WIDTH  = RATE_WIDTH_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_wr_en,
    input  logic [WEIGHT_W-1:0]     cfg_wr_data,
    input  logic [CODE_W-1:0]       rate_code,
    input  logic [RATE_WIDTH-1:0]   data_rate,
    input  logic [RATIO_WIDTH-1:0]  psr_oldest,
    input  logic [RATIO_WIDTH-1:0]  psr_older,
    input  logic [RATIO_WIDTH-1:0]  psr_newest,
    input  logic                    last_entry,
    input  logic [CODE_W-1:0]       alt_rate_code,
    input  logic [ROLL_W-1:0]       sample_roll,
    input  logic [CODE_W-1:0]       sample_rate_code,
    input  logic [RATE_WIDTH-1:0]   sample_data_rate,
    input  logic                    no_updates,
    input  ctrl_cmd_t               cmd,
    output ctrl_status_t            status_out,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [STATUS_W-1:0]     status,
    output logic [CODE_W-1:0]       rate_first,
    output logic [CODE_W-1:0]       rate_second,
    output logic [CODE_W-1:0]       rate_third,
    output logic [CODE_W-1:0]       rate_fourth
);

    localparam int MIX_W      = RATIO_WIDTH + WEIGHT_W;
    localparam int DIV_CYCLES = (MIX_W + DIV_BITS - 1) / DIV_BITS;
    localparam int NUM_W      = DIV_CYCLES * DIV_BITS;
    localparam int TP_W       = RATIO_WIDTH + RATE_WIDTH;
    localparam int CS_W       = RATE_WIDTH + TP_SCALE_W;
    localparam int CMP_W      = (CS_W > TP_W) ? CS_W : TP_W;
    localparam int SAT_W      = (RATE_WIDTH > RATIO_WIDTH) ? RATE_WIDTH : RATIO_WIDTH;
    localparam int REM_W      = WEIGHT_W;

    // captured item
    logic [CODE_W-1:0]      code_reg;
    logic [RATE_WIDTH-1:0]  rate_reg;
    logic [RATIO_WIDTH-1:0] oldest_reg;
    logic [RATIO_WIDTH-1:0] older_reg;
    logic [RATIO_WIDTH-1:0] newest_reg;
    logic                   last_reg;
    logic [CODE_W-1:0]      alt_code_reg;
    logic [ROLL_W-1:0]      roll_reg;
    logic [CODE_W-1:0]      cand_code_reg;
    logic [RATE_WIDTH-1:0]  cand_rate_reg;
    logic                   no_upd_reg;

    logic [WEIGHT_W-1:0]    weight_reg;

    // divide unit: numerator shifts out at the top, quotient shifts in at the bottom
    logic [NUM_W-1:0]       num_reg, num_next;
    logic [REM_W-1:0]       rem_reg, rem_next;
    logic [TP_W-1:0]        tp_reg;
    logic [CS_W-1:0]        cand_scaled_reg;

    // running selection state
    logic [RATIO_WIDTH-1:0] best_ratio_reg;
    logic [RATE_WIDTH-1:0]  best_ratio_rate_reg;
    logic [CODE_W-1:0]      best_ratio_code_reg;
    logic [TP_W-1:0]        best_tp_reg;
    logic [CODE_W-1:0]      best_tp_code_reg;
    logic [TP_W-1:0]        runner_tp_reg;
    logic [CODE_W-1:0]      runner_tp_code_reg;
    logic [RATE_WIDTH-1:0]  low_rate_reg;
    logic [CODE_W-1:0]      low_code_reg;
    logic [RATE_WIDTH-1:0]  second_low_rate_reg;
    logic [CODE_W-1:0]      second_low_code_reg;
    logic [CODE_W-1:0]      chosen_reg [4];
    // throughput behind the scaled best; compared against candidate rate times scale
    logic [TP_W-1:0]        tp_hold_reg;

    logic                   out_valid_reg;
    logic [STATUS_W-1:0]    status_reg;
    logic [CODE_W-1:0]      first_reg;
    logic [CODE_W-1:0]      second_reg;
    logic [CODE_W-1:0]      third_reg;
    logic [CODE_W-1:0]      fourth_reg;

    logic [WEIGHT_W-1:0]    w_sat;
    logic [WEIGHT_W-1:0]    w_inv;
    logic [RATIO_WIDTH-1:0] mix_a;
    logic [RATIO_WIDTH-1:0] mix_b;
    logic [MIX_W-1:0]       mix_sum;
    logic [RATIO_WIDTH-1:0] ratio;

    logic [DIV_BITS-1:0]    div_top;
    logic [DIV_BITS-1:0]    div_q;
    logic [REM_W:0]         div_t;
    logic [REM_W-1:0]       div_r;

    logic [RATIO_WIDTH-1:0] upd_best_ratio;
    logic [RATE_WIDTH-1:0]  upd_best_ratio_rate;
    logic [CODE_W-1:0]      upd_best_ratio_code;
    logic [TP_W-1:0]        upd_best_tp;
    logic [CODE_W-1:0]      upd_best_tp_code;
    logic [TP_W-1:0]        upd_runner_tp;
    logic [CODE_W-1:0]      upd_runner_tp_code;
    logic [RATE_WIDTH-1:0]  upd_low_rate;
    logic [CODE_W-1:0]      upd_low_code;
    logic [RATE_WIDTH-1:0]  upd_second_low_rate;
    logic [CODE_W-1:0]      upd_second_low_code;
    logic [TP_W-1:0]        upd_tp_hold;
    logic [CODE_W-1:0]      commit_third;

    logic                   sample;
    logic                   collide;
    logic                   cand_higher;

    assign w_sat   = (weight_reg > PERCENT) ? PERCENT : weight_reg;
    assign w_inv   = PERCENT - w_sat;
    assign ratio   = num_reg[RATIO_WIDTH-1:0];
    assign mix_a   = cmd.mix_second ? ratio : oldest_reg;
    assign mix_b   = cmd.mix_second ? newest_reg : older_reg;
    assign mix_sum = MIX_W'(mix_a) * MIX_W'(w_sat) + MIX_W'(mix_b) * MIX_W'(w_inv);
    assign div_top = num_reg[NUM_W-1 -: DIV_BITS];

    // restoring division by hundred, one quotient byte per cycle
    always_comb
    begin
        div_r = rem_reg;
        div_q = '0;
        div_t = '0;
        for (int i = 0; i < DIV_BITS; i++)
        begin
            div_t = {div_r, div_top[DIV_BITS-1-i]};
            if (div_t >= {1'b0, PERCENT})
            begin
                div_t                 = div_t - {1'b0, PERCENT};
                div_q[DIV_BITS-1-i]   = 1'b1;
            end
            div_r = div_t[REM_W-1:0];
        end
    end

    always_comb
    begin
        num_next = num_reg;
        rem_next = rem_reg;
        if (cmd.mix_load)
        begin
            num_next = NUM_W'(mix_sum);
            rem_next = '0;
        end
        else if (cmd.div_step)
        begin
            num_next = {num_reg[NUM_W-DIV_BITS-1:0], div_q};
            rem_next = div_r;
        end
    end

    // running selection with this entry folded in
    always_comb
    begin
        upd_best_ratio      = best_ratio_reg;
        upd_best_ratio_rate = best_ratio_rate_reg;
        upd_best_ratio_code = best_ratio_code_reg;
        upd_best_tp         = best_tp_reg;
        upd_best_tp_code    = best_tp_code_reg;
        upd_runner_tp       = runner_tp_reg;
        upd_runner_tp_code  = runner_tp_code_reg;
        upd_low_rate        = low_rate_reg;
        upd_low_code        = low_code_reg;
        upd_second_low_rate = second_low_rate_reg;
        upd_second_low_code = second_low_code_reg;
        upd_tp_hold         = tp_hold_reg;

        if (ratio > best_ratio_reg ||
            (ratio == best_ratio_reg && ratio != '0 && rate_reg > best_ratio_rate_reg))
        begin
            upd_best_ratio      = ratio;
            upd_best_ratio_rate = rate_reg;
            upd_best_ratio_code = code_reg;
        end

        if (tp_reg > best_tp_reg)
        begin
            upd_runner_tp      = best_tp_reg;
            upd_runner_tp_code = best_tp_code_reg;
            upd_best_tp        = tp_reg;
            upd_best_tp_code   = code_reg;
            upd_tp_hold        = tp_reg;
        end
        else if (tp_reg > runner_tp_reg)
        begin
            upd_runner_tp      = tp_reg;
            upd_runner_tp_code = code_reg;
        end

        if (low_rate_reg == '0 || low_rate_reg > rate_reg)
        begin
            upd_second_low_rate = low_rate_reg;
            upd_second_low_code = low_code_reg;
            upd_low_rate        = rate_reg;
            upd_low_code        = code_reg;
        end
        else if (second_low_rate_reg == '0 || second_low_rate_reg > rate_reg)
        begin
            upd_second_low_rate = rate_reg;
            upd_second_low_code = code_reg;
        end

        if (upd_best_ratio_code == upd_best_tp_code ||
            upd_best_ratio_code == upd_runner_tp_code ||
            upd_best_ratio_code == upd_low_code)
            commit_third = upd_second_low_code;
        else
            commit_third = upd_best_ratio_code;
    end

    assign sample  = no_upd_reg || (roll_reg < SAMPLE_PERCENT);
    assign collide = (cand_code_reg == chosen_reg[0]) || (cand_code_reg == chosen_reg[1]) ||
                     (cand_code_reg == chosen_reg[2]) || (cand_code_reg == chosen_reg[3]);
    // rate above the saturated scaled best throughput
    assign cand_higher = (CMP_W'(cand_scaled_reg) > CMP_W'(tp_hold_reg)) ||
                         (SAT_W'(cand_rate_reg) > SAT_W'({RATIO_WIDTH{1'b1}}));

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            code_reg      <= rate_code;
            rate_reg      <= data_rate;
            oldest_reg    <= psr_oldest;
            older_reg     <= psr_older;
            newest_reg    <= psr_newest;
            last_reg      <= last_entry;
            alt_code_reg  <= alt_rate_code;
            roll_reg      <= sample_roll;
            cand_code_reg <= sample_rate_code;
            cand_rate_reg <= sample_data_rate;
            no_upd_reg    <= no_updates;
        end
        num_reg <= num_next;
        rem_reg <= rem_next;
        if (cmd.tp_load)
            tp_reg <= TP_W'(ratio) * TP_W'(rate_reg);
        if (cmd.req_mul)
            cand_scaled_reg <= CS_W'(cand_rate_reg) * CS_W'(TP_SCALE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_reg <= WEIGHT_RESET;
        end
        else if (cfg_wr_en)
        begin
            weight_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_ratio_reg      <= '0;
            best_ratio_rate_reg <= '0;
            best_ratio_code_reg <= '0;
            best_tp_reg         <= '0;
            best_tp_code_reg    <= '0;
            runner_tp_reg       <= '0;
            runner_tp_code_reg  <= '0;
            low_rate_reg        <= '0;
            low_code_reg        <= '0;
            second_low_rate_reg <= '0;
            second_low_code_reg <= '0;
            tp_hold_reg         <= '0;
            for (int i = 0; i < 4; i++)
            begin
                chosen_reg[i] <= '0;
            end
        end
        else if (cmd.entry_update)
        begin
            tp_hold_reg <= upd_tp_hold;
            if (last_reg)
            begin
                chosen_reg[0]       <= upd_best_tp_code;
                chosen_reg[1]       <= upd_runner_tp_code;
                chosen_reg[2]       <= commit_third;
                chosen_reg[3]       <= upd_low_code;
                best_ratio_reg      <= '0;
                best_ratio_rate_reg <= '0;
                best_ratio_code_reg <= '0;
                best_tp_reg         <= '0;
                best_tp_code_reg    <= '0;
                runner_tp_reg       <= '0;
                runner_tp_code_reg  <= '0;
                low_rate_reg        <= '0;
                low_code_reg        <= '0;
                second_low_rate_reg <= '0;
                second_low_code_reg <= '0;
            end
            else
            begin
                best_ratio_reg      <= upd_best_ratio;
                best_ratio_rate_reg <= upd_best_ratio_rate;
                best_ratio_code_reg <= upd_best_ratio_code;
                best_tp_reg         <= upd_best_tp;
                best_tp_code_reg    <= upd_best_tp_code;
                runner_tp_reg       <= upd_runner_tp;
                runner_tp_code_reg  <= upd_runner_tp_code;
                low_rate_reg        <= upd_low_rate;
                low_code_reg        <= upd_low_code;
                second_low_rate_reg <= upd_second_low_rate;
                second_low_code_reg <= upd_second_low_code;
            end
        end
        else if (cmd.empty_apply)
        begin
            for (int i = 0; i < 4; i++)
            begin
                chosen_reg[i] <= code_reg;
            end
            tp_hold_reg         <= '0;
            best_ratio_reg      <= '0;
            best_ratio_rate_reg <= '0;
            best_ratio_code_reg <= '0;
            best_tp_reg         <= '0;
            best_tp_code_reg    <= '0;
            runner_tp_reg       <= '0;
            runner_tp_code_reg  <= '0;
            low_rate_reg        <= '0;
            low_code_reg        <= '0;
            second_low_rate_reg <= '0;
            second_low_code_reg <= alt_code_reg;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((cmd.entry_update && last_reg) || cmd.req_out || cmd.empty_apply)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.entry_update && last_reg)
        begin
            status_reg <= STATUS_COMMITTED;
            first_reg  <= upd_best_tp_code;
            second_reg <= upd_runner_tp_code;
            third_reg  <= commit_third;
            fourth_reg <= upd_low_code;
        end
        else if (cmd.empty_apply)
        begin
            status_reg <= STATUS_COMMITTED;
            first_reg  <= code_reg;
            second_reg <= code_reg;
            third_reg  <= code_reg;
            fourth_reg <= code_reg;
        end
        else if (cmd.req_out)
        begin
            if (sample && collide)
            begin
                status_reg <= STATUS_REDRAW;
                first_reg  <= '0;
                second_reg <= '0;
                third_reg  <= '0;
                fourth_reg <= '0;
            end
            else
            begin
                status_reg <= STATUS_CHAIN;
                third_reg  <= chosen_reg[2];
                fourth_reg <= chosen_reg[3];
                if (!sample)
                begin
                    first_reg  <= chosen_reg[0];
                    second_reg <= chosen_reg[1];
                end
                else if (cand_higher)
                begin
                    first_reg  <= cand_code_reg;
                    second_reg <= chosen_reg[0];
                end
                else
                begin
                    first_reg  <= chosen_reg[0];
                    second_reg <= cand_code_reg;
                end
            end
        end
    end

    assign status_out.last_entry = last_reg;
    assign status_out.out_free   = !out_valid_reg || out_ready;

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign rate_first  = first_reg;
    assign rate_second = second_reg;
    assign rate_third  = third_reg;
    assign rate_fourth = fourth_reg;

endmodule

[rtl/minstrel_rate_table_select_top.sv]
// Rate selector for one neighbour: rate entry updates, empty table reset and
// retry chain requests. Instantiates mrts_ctrl and mrts_datapath; uses mrts_pkg.
//
// One item is in work at a time; in_ready is high only while the block is idle.
// A rate entry steps through ST_MIX1, ST_DIV1, ST_MIX2, ST_DIV2, ST_TP and
// ST_UPDATE, running the divide-by-hundred unit, eight quotient bits per pass,
// once for each of the two smoothing steps. A packet request passes through
// ST_REQ_MUL and ST_REQ_OUT, an empty table reset through ST_EMPTY; an unused
// mode code is dropped. A result sits in an output register
// until taken, and the block stalls only when a second result is ready while
// the first still waits. smoothing_weight may be written at any time the block
// is idle; values above 100 act as 100.
`timescale 1ns / 1ps

module minstrel_rate_table_select_top
    import mrts_pkg::*;
#(
    parameter int RATIO_WIDTH = RATIO_WIDTH_DEF,
    parameter int RATE_WIDTH  = RATE_WIDTH_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_wr_en,
    input  logic [WEIGHT_W-1:0]     cfg_wr_data,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [MODE_W-1:0]       mode,
    input  logic [CODE_W-1:0]       rate_code,
    input  logic [RATE_WIDTH-1:0]   data_rate,
    input  logic [RATIO_WIDTH-1:0]  psr_oldest,
    input  logic [RATIO_WIDTH-1:0]  psr_older,
    input  logic [RATIO_WIDTH-1:0]  psr_newest,
    input  logic                    last_entry,
    input  logic [CODE_W-1:0]       alt_rate_code,
    input  logic [ROLL_W-1:0]       sample_roll,
    input  logic [CODE_W-1:0]       sample_rate_code,
    input  logic [RATE_WIDTH-1:0]   sample_data_rate,
    input  logic                    no_updates,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [STATUS_W-1:0]     status,
    output logic [CODE_W-1:0]       rate_first,
    output logic [CODE_W-1:0]       rate_second,
    output logic [CODE_W-1:0]       rate_third,
    output logic [CODE_W-1:0]       rate_fourth
);

    ctrl_cmd_t    cmd;
    ctrl_status_t dp_status;

    mrts_ctrl #(
        .RATIO_WIDTH (RATIO_WIDTH)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .mode       (mode),
        .status_in  (dp_status),
        .cmd        (cmd)
    );

    mrts_datapath #(
        .RATIO_WIDTH (RATIO_WIDTH),
        .RATE_WIDTH  (RATE_WIDTH)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .rate_code        (rate_code),
        .data_rate        (data_rate),
        .psr_oldest       (psr_oldest),
        .psr_older        (psr_older),
        .psr_newest       (psr_newest),
        .last_entry       (last_entry),
        .alt_rate_code    (alt_rate_code),
        .sample_roll      (sample_roll),
        .sample_rate_code (sample_rate_code),
        .sample_data_rate (sample_data_rate),
        .no_updates       (no_updates),
        .cmd              (cmd),
        .status_out       (dp_status),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .status           (status),
        .rate_first       (rate_first),
        .rate_second      (rate_second),
        .rate_third       (rate_third),
        .rate_fourth      (rate_fourth)
    );

endmodule
